[sv/wpc_pkg.sv]
package wpc_pkg;

    // width of the window register on the config port
    localparam int WIN_BITS  = 9;
    localparam int WIN_RESET = 16;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LIN,
        S_OXX,
        S_OYY,
        S_OXY,
        S_NXX,
        S_NYY,
        S_NXY,
        S_CHK,
        S_T1,
        S_T2,
        S_T3,
        S_T4,
        S_T5,
        S_T6,
        S_DCHK,
        S_PXY,
        S_MSQ,
        S_DIV,
        S_SQRT,
        S_OUT
    } t_state;

endpackage

[sv/wpc_mul.sv]
// Iterative signed shift-add multiplier; stops as soon as b runs out of ones.
module wpc_mul #(
    parameter int OPW = 51
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [OPW-1:0]   i_a,
    input  logic signed [OPW-1:0]   i_b,
    output logic                    o_done,
    output logic signed [2*OPW-1:0] o_prod
);
    logic             r_run;
    logic             r_neg;
    logic [2*OPW-1:0] r_a;
    logic [2*OPW-1:0] r_acc;
    logic [OPW-1:0]   r_b;
    logic [OPW-1:0]   abs_a;
    logic [OPW-1:0]   abs_b;

    assign abs_a = i_a[OPW-1] ? OPW'(-i_a) : OPW'(i_a);
    assign abs_b = i_b[OPW-1] ? OPW'(-i_b) : OPW'(i_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start) begin
            r_run <= 1'b1;
        end else if (o_done) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= (2*OPW)'(abs_a);
            r_b   <= abs_b;
            r_acc <= '0;
            r_neg <= i_a[OPW-1] ^ i_b[OPW-1];
        end else if (r_run && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_run && (r_b == '0);
    assign o_prod = r_neg ? $signed(-r_acc) : $signed(r_acc);

endmodule

[sv/windowed_pearson_correlation_unit.sv]
// Windowed Pearson correlation. Each input beat carries one (x, y) pair with a
// present flag per sample; each input beat yields exactly one output beat with
// the correlation over the last window_length pairs in Q1.(CORR_BITS-1), +1
// saturating to the largest positive code, and a valid flag that is low (with
// the value forced to zero) until a full window has been seen, when fewer than
// two pairs in the window have both samples, or when either series is flat.
// Writing the window register (0 acts as 1, above MAX_WINDOW acts as
// MAX_WINDOW) clears the history. One item at a time: the input is ready only
// while the sequencer is idle. All products go through one shift-add
// multiplier, followed by a restoring divider and a digit-by-digit square
// root. The multiplier dominates the time an item takes, and a stall on the
// output adds to it. The history RAM needs no clearing pass.
module windowed_pearson_correlation_unit #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int CORR_BITS   = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // x_sample, x_present, y_sample, y_present
    input  logic [((2*SAMPLE_BITS+9)/8)*8-1:0]         i_s_axis_tdata,
    input  logic                                       i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // correlation, correlation_valid
    output logic [((CORR_BITS+8)/8)*8-1:0]             o_m_axis_tdata,
    output logic                                       o_m_axis_tvalid,
    input  logic                                       i_m_axis_tready,
    input  logic [wpc_pkg::WIN_BITS-1:0]               i_cfg_data,
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready
);
    import wpc_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int CB   = CORR_BITS;
    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int NW   = $clog2(MAX_WINDOW + 1);
    localparam int S1W  = SB + AW + 1;               // sum of samples
    localparam int S2W  = 2*SB + AW + 1;             // sums of squares / products
    localparam int NUMW = ((NW + S2W) > 2*S1W ? NW + S2W : 2*S1W) + 1;
    localparam int PW   = 2*NUMW;                    // multiplier product
    localparam int QW   = 2*CB + 2;                  // quotient, even for the root
    localparam int QH   = QW / 2;
    localparam int RW   = CB + 2;                    // root remainder
    localparam int CNTW = $clog2(QW);
    localparam int OUTW = ((CB + 8) / 8) * 8;
    localparam int WIN_RST = (MAX_WINDOW < WIN_RESET) ? MAX_WINDOW : WIN_RESET;
    localparam logic [CB:0] LO_SAT = (CB+1)'(2**(CB-1));

    t_state r_state;
    t_state n_state;

    // control state
    logic [NW-1:0]           r_win;
    logic [NW-1:0]           r_seen;
    logic [AW-1:0]           r_wpos;
    logic [NW-1:0]           r_n;
    logic signed [S1W-1:0]   r_sx;
    logic signed [S1W-1:0]   r_sy;
    logic signed [S2W-1:0]   r_sxx;
    logic signed [S2W-1:0]   r_syy;
    logic signed [S2W-1:0]   r_sxy;
    logic                    r_mrun;
    logic                    r_ovalid;

    // payload
    logic [2*SB:0]           mem [MAX_WINDOW];
    logic [2*SB:0]           r_rd;
    logic signed [SB-1:0]    r_x;
    logic signed [SB-1:0]    r_y;
    logic                    r_both;
    logic                    r_drop_en;
    logic                    r_ok;
    logic signed [NUMW-1:0]  r_num;
    logic signed [NUMW-1:0]  r_dx;
    logic signed [NUMW-1:0]  r_dy;
    logic [PW-1:0]           r_pxy;
    logic [PW-1:0]           r_rem;
    logic [QW-1:0]           r_dq;
    logic [QW-1:0]           r_q;
    logic [RW-1:0]           r_srem;
    logic [CB:0]             r_root;
    logic [CNTW-1:0]         r_cnt;
    logic signed [CB-1:0]    r_corr;
    logic                    r_cvalid;

    // comb
    logic                    in_acc;
    logic                    cfg_acc;
    logic                    out_free;
    logic                    drop;
    logic                    step;
    logic                    mul_start;
    logic                    mul_done;
    logic signed [NUMW-1:0]  mul_a;
    logic signed [NUMW-1:0]  mul_b;
    logic signed [PW-1:0]    prod;
    logic signed [SB-1:0]    in_x;
    logic signed [SB-1:0]    in_y;
    logic                    in_both;
    logic signed [SB-1:0]    old_x;
    logic signed [SB-1:0]    old_y;
    logic [NW-1:0]           wpos_inc;
    logic [PW:0]             t_div;
    logic [PW:0]             d_sub;
    logic                    d_ge;
    logic [CB+3:0]           t_sq;
    logic [CB+3:0]           trial;
    logic                    s_ge;
    logic [CB+1:0]           s_inc;
    logic [CB:0]             lo;
    logic [CB:0]             lo_neg;
    logic signed [CB-1:0]    corr;

    assign in_x    = i_s_axis_tdata[SB-1:0];
    assign in_y    = i_s_axis_tdata[2*SB:SB+1];
    assign in_both = i_s_axis_tdata[SB] & i_s_axis_tdata[2*SB+1];
    assign old_x   = r_rd[SB-1:0];
    assign old_y   = r_rd[2*SB-1:SB];

    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ovalid || i_m_axis_tready;
    assign drop     = r_drop_en & r_rd[2*SB];
    assign step     = r_mrun && mul_done;
    assign wpos_inc = NW'(r_wpos) + NW'(1);

    // divider step: one quotient bit per cycle
    assign t_div = {r_rem, r_dq[QW-1]};
    assign d_sub = t_div - {1'b0, r_pxy};
    assign d_ge  = (t_div >= {1'b0, r_pxy});

    // square root step: one root bit per cycle
    assign t_sq  = {r_srem, r_q[QW-1:QW-2]};
    assign trial = (CB+4)'({r_root, 2'b01});
    assign s_ge  = (t_sq >= trial);

    // magnitude = round-half-up of sqrt(Q) / 2
    assign s_inc  = {1'b0, r_root} + (CB+2)'(1);
    assign lo     = s_inc[CB+1:1];
    assign lo_neg = (CB+1)'(0) - lo;
    always_comb begin
        if (r_num[NUMW-1]) begin
            corr = lo_neg[CB-1:0];
        end else if (lo >= LO_SAT) begin
            corr = CB'(LO_SAT - (CB+1)'(1));
        end else begin
            corr = lo[CB-1:0];
        end
    end

    wpc_mul #(
        .OPW (NUMW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_LIN;
            S_LIN: begin
                if (drop) begin
                    n_state = S_OXX;
                end else if (r_both) begin
                    n_state = S_NXX;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_OXX: if (step) n_state = S_OYY;
            S_OYY: if (step) n_state = S_OXY;
            S_OXY: if (step) n_state = r_both ? S_NXX : S_CHK;
            S_NXX: if (step) n_state = S_NYY;
            S_NYY: if (step) n_state = S_NXY;
            S_NXY: if (step) n_state = S_CHK;
            S_CHK: begin
                n_state = (r_seen >= r_win && r_n >= NW'(2)) ? S_T1 : S_OUT;
            end
            S_T1: if (step) n_state = S_T2;
            S_T2: if (step) n_state = S_T3;
            S_T3: if (step) n_state = S_T4;
            S_T4: if (step) n_state = S_T5;
            S_T5: if (step) n_state = S_T6;
            S_T6: if (step) n_state = S_DCHK;
            S_DCHK: n_state = (r_dx > 0 && r_dy > 0) ? S_PXY : S_OUT;
            S_PXY: if (step) n_state = S_MSQ;
            S_MSQ: if (step) n_state = S_DIV;
            S_DIV: if (r_cnt == '0) n_state = S_SQRT;
            S_SQRT: if (r_cnt == '0) n_state = S_OUT;
            S_OUT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // multiplier operands
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            S_OXX: begin mul_start = 1'b1; mul_a = NUMW'(old_x); mul_b = NUMW'(old_x); end
            S_OYY: begin mul_start = 1'b1; mul_a = NUMW'(old_y); mul_b = NUMW'(old_y); end
            S_OXY: begin mul_start = 1'b1; mul_a = NUMW'(old_x); mul_b = NUMW'(old_y); end
            S_NXX: begin mul_start = 1'b1; mul_a = NUMW'(r_x); mul_b = NUMW'(r_x); end
            S_NYY: begin mul_start = 1'b1; mul_a = NUMW'(r_y); mul_b = NUMW'(r_y); end
            S_NXY: begin mul_start = 1'b1; mul_a = NUMW'(r_x); mul_b = NUMW'(r_y); end
            S_T1:  begin mul_start = 1'b1; mul_a = NUMW'(r_sxy); mul_b = NUMW'(r_n); end
            S_T2:  begin mul_start = 1'b1; mul_a = NUMW'(r_sx); mul_b = NUMW'(r_sy); end
            S_T3:  begin mul_start = 1'b1; mul_a = NUMW'(r_sxx); mul_b = NUMW'(r_n); end
            S_T4:  begin mul_start = 1'b1; mul_a = NUMW'(r_sx); mul_b = NUMW'(r_sx); end
            S_T5:  begin mul_start = 1'b1; mul_a = NUMW'(r_syy); mul_b = NUMW'(r_n); end
            S_T6:  begin mul_start = 1'b1; mul_a = NUMW'(r_sy); mul_b = NUMW'(r_sy); end
            S_PXY: begin mul_start = 1'b1; mul_a = r_dx; mul_b = r_dy; end
            S_MSQ: begin mul_start = 1'b1; mul_a = r_num; mul_b = r_num; end
            default: ;
        endcase
        mul_start = mul_start && !r_mrun;
    end

    // control registers and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mrun   <= 1'b0;
            r_win    <= NW'(WIN_RST);
            r_seen   <= '0;
            r_wpos   <= '0;
            r_n      <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_sxx    <= '0;
            r_syy    <= '0;
            r_sxy    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mrun  <= mul_start | (r_mrun & ~mul_done);
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_acc) begin
                if (i_cfg_data == '0) begin
                    r_win <= NW'(1);
                end else if (int'(i_cfg_data) > MAX_WINDOW) begin
                    r_win <= NW'(MAX_WINDOW);
                end else begin
                    r_win <= NW'(i_cfg_data);
                end
                r_seen <= '0;
                r_wpos <= '0;
                r_n    <= '0;
                r_sx   <= '0;
                r_sy   <= '0;
                r_sxx  <= '0;
                r_syy  <= '0;
                r_sxy  <= '0;
            end
            if (in_acc) begin
                if (r_seen < r_win) begin
                    r_seen <= r_seen + NW'(1);
                end
                r_wpos <= (wpos_inc >= r_win) ? '0 : wpos_inc[AW-1:0];
            end
            unique case (r_state)
                S_LIN: begin
                    r_sx <= r_sx - (drop ? S1W'(old_x) : '0) + (r_both ? S1W'(r_x) : '0);
                    r_sy <= r_sy - (drop ? S1W'(old_y) : '0) + (r_both ? S1W'(r_y) : '0);
                    r_n  <= r_n - NW'(drop) + NW'(r_both);
                end
                S_OXX: if (step) r_sxx <= r_sxx - prod[S2W-1:0];
                S_OYY: if (step) r_syy <= r_syy - prod[S2W-1:0];
                S_OXY: if (step) r_sxy <= r_sxy - prod[S2W-1:0];
                S_NXX: if (step) r_sxx <= r_sxx + prod[S2W-1:0];
                S_NYY: if (step) r_syy <= r_syy + prod[S2W-1:0];
                S_NXY: if (step) r_sxy <= r_sxy + prod[S2W-1:0];
                default: ;
            endcase
        end
    end

    // history RAM, read-first
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mem[r_wpos] <= {in_both, in_y, in_x};
            r_rd        <= mem[r_wpos];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x       <= in_x;
            r_y       <= in_y;
            r_both    <= in_both;
            r_drop_en <= (r_seen >= r_win);
            r_ok      <= 1'b0;
        end
        unique case (r_state)
            S_T1: if (step) r_num <= prod[NUMW-1:0];
            S_T2: if (step) r_num <= r_num - prod[NUMW-1:0];
            S_T3: if (step) r_dx <= prod[NUMW-1:0];
            S_T4: if (step) r_dx <= r_dx - prod[NUMW-1:0];
            S_T5: if (step) r_dy <= prod[NUMW-1:0];
            S_T6: if (step) r_dy <= r_dy - prod[NUMW-1:0];
            S_DCHK: r_ok <= (r_dx > 0 && r_dy > 0);
            S_PXY: if (step) r_pxy <= prod;
            S_MSQ: begin
                if (step) begin
                    // numerator squared times 2^(2*CB), split across rem and dq
                    r_rem <= prod >> 2;
                    r_dq  <= {prod[1:0], (QW-2)'(0)};
                    r_cnt <= CNTW'(QW - 1);
                end
            end
            S_DIV: begin
                r_rem <= d_ge ? d_sub[PW-1:0] : t_div[PW-1:0];
                r_q   <= {r_q[QW-2:0], d_ge};
                r_dq  <= r_dq << 1;
                if (r_cnt == '0) begin
                    r_srem <= '0;
                    r_root <= '0;
                    r_cnt  <= CNTW'(QH - 1);
                end else begin
                    r_cnt <= r_cnt - CNTW'(1);
                end
            end
            S_SQRT: begin
                r_srem <= s_ge ? RW'(t_sq - trial) : RW'(t_sq);
                r_root <= {r_root[CB-1:0], s_ge};
                r_q    <= r_q << 2;
                r_cnt  <= r_cnt - CNTW'(1);
            end
            S_OUT: begin
                if (out_free) begin
                    r_corr   <= r_ok ? corr : '0;
                    r_cvalid <= r_ok;
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OUTW'({r_cvalid, r_corr});

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_LIN))
        else $error("accepted item did not start the sequencer");
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= r_win)
        else $error("item count above window length");
    a_wpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NW'(r_wpos) < r_win)
        else $error("write position outside window");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !r_cvalid) |-> (r_corr == '0))
        else $error("invalid result carries a nonzero value");

endmodule
